FILE: rtl/core/mawt_pkg.sv
// ----------------------------------------------------------------------------
// mawt_pkg: shared types and constants of the multi-axis window trigger
// Holds the transfer payloads, the per-lane flag pair, the change codes and
// the configuration register indexes.
// ----------------------------------------------------------------------------
package mawt_pkg;

  // Fixed field widths.
  localparam int VALUE_BITS  = 16;
  localparam int MAX_AXES    = 4;
  localparam int BOUND_BITS  = 16;
  localparam int MARGIN_BITS = 15;
  localparam int WIN_BITS    = 2 * BOUND_BITS + MARGIN_BITS;
  localparam int MASK_BITS   = MAX_AXES;

  // Comparison width: holds any value, the lower bound minus the margin and
  // the upper bound plus the margin exactly.
  localparam int CMP_BITS = (VALUE_BITS > BOUND_BITS + 2) ? VALUE_BITS : BOUND_BITS + 2;

  // Window register layout.
  localparam int WIN_LO_LSB = 0;
  localparam int WIN_HI_LSB = BOUND_BITS;
  localparam int WIN_M_LSB  = 2 * BOUND_BITS;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE   = 3'd5;

  typedef enum logic [1:0] {
    CHG_NONE     = 2'd0,
    CHG_FIRED    = 2'd1,
    CHG_RELEASED = 2'd2
  } change_code_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] axis_value_0;
    logic signed [VALUE_BITS-1:0] axis_value_1;
    logic signed [VALUE_BITS-1:0] axis_value_2;
    logic signed [VALUE_BITS-1:0] axis_value_3;
    logic [MASK_BITS-1:0]         present_mask;
    logic                         point_valid;
    logic                         last_point;
  } in_item_t;

  typedef struct packed {
    change_code_t change_code;
    logic         triggered_now;
  } out_item_t;

  // What one axis lane finds for the current point.
  typedef struct packed {
    logic is_inside;
    logic is_outside;
  } lane_flags_t;

endpackage

FILE: rtl/core/mawt_lane.sv
// ----------------------------------------------------------------------------
// mawt_lane: window test of one axis
// Compares one axis value against its plain window and its window widened
// by the margin, and reports whether the axis counts as inside and outside.
// ----------------------------------------------------------------------------
module mawt_lane
  import mawt_pkg::*;
(
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         present,
  input  logic                         enable,
  input  logic                         invert,
  input  logic [WIN_BITS-1:0]          window,
  output lane_flags_t                  flags
);

  logic signed [BOUND_BITS-1:0] lo;
  logic signed [BOUND_BITS-1:0] hi;
  logic [MARGIN_BITS-1:0]       margin;
  logic signed [CMP_BITS-1:0]   v_w;
  logic signed [CMP_BITS-1:0]   lo_w;
  logic signed [CMP_BITS-1:0]   hi_w;
  logic signed [CMP_BITS-1:0]   m_w;
  logic signed [CMP_BITS-1:0]   wlo;
  logic signed [CMP_BITS-1:0]   whi;
  logic                         in_plain;
  logic                         beyond_wide;

  assign lo     = window[WIN_LO_LSB +: BOUND_BITS];
  assign hi     = window[WIN_HI_LSB +: BOUND_BITS];
  assign margin = window[WIN_M_LSB +: MARGIN_BITS];

  assign v_w  = CMP_BITS'(value);
  assign lo_w = CMP_BITS'(lo);
  assign hi_w = CMP_BITS'(hi);
  assign m_w  = CMP_BITS'($signed({1'b0, margin}));
  assign wlo  = lo_w - m_w;
  assign whi  = hi_w + m_w;

  assign in_plain    = (v_w >= lo_w) && (v_w <= hi_w);
  assign beyond_wide = (v_w <= wlo) || (v_w >= whi);

  always_comb begin
    if (!enable) begin
      // A disabled axis never vetoes inside and never makes a point outside.
      flags.is_inside  = 1'b1;
      flags.is_outside = 1'b0;
    end else if (!present) begin
      flags.is_inside  = 1'b0;
      flags.is_outside = 1'b1;
    end else if (invert) begin
      flags.is_inside  = beyond_wide;
      flags.is_outside = in_plain;
    end else begin
      flags.is_inside  = in_plain;
      flags.is_outside = beyond_wide;
    end
  end

endmodule

FILE: rtl/core/mawt_merge.sv
// ----------------------------------------------------------------------------
// mawt_merge: lane merge, update accumulators and hysteresis
// Folds the lane flags into one point verdict, accumulates it over the
// update and decides fire or release when the update ends.
// ----------------------------------------------------------------------------
module mawt_merge
  import mawt_pkg::*;
#(
  parameter int AXES = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_accept,
  input  logic                   point_valid,
  input  logic                   last_point,
  input  lane_flags_t [AXES-1:0] lane_flags,
  output logic                   res_push,
  output out_item_t              res_item
);

  logic [AXES-1:0] inside_vec;
  logic [AXES-1:0] outside_vec;
  logic            point_inside;
  logic            point_outside;
  logic            acc_inside;
  logic            acc_outside;
  logic            update_end;

  logic armed_r, armed_nxt;
  logic any_inside_r, any_inside_nxt;
  logic all_outside_r, all_outside_nxt;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      inside_vec[i]  = lane_flags[i].is_inside;
      outside_vec[i] = lane_flags[i].is_outside;
    end
  end

  assign point_inside  = &inside_vec;
  assign point_outside = |outside_vec;

  // Fold the current point in, if the transfer carries one.
  assign acc_inside  = any_inside_r || (point_valid && point_inside);
  assign acc_outside = all_outside_r && (!point_valid || point_outside);
  assign update_end  = !point_valid || last_point;
  assign res_push    = item_accept && update_end;

  always_comb begin
    armed_nxt       = armed_r;
    any_inside_nxt  = any_inside_r;
    all_outside_nxt = all_outside_r;
    res_item.change_code = CHG_NONE;
    if (!armed_r) begin
      if (acc_inside) begin
        res_item.change_code = CHG_FIRED;
      end
    end else begin
      if (acc_outside) begin
        res_item.change_code = CHG_RELEASED;
      end
    end
    res_item.triggered_now = (res_item.change_code == CHG_FIRED) ||
                             (armed_r && (res_item.change_code == CHG_NONE));
    if (item_accept) begin
      if (update_end) begin
        armed_nxt       = res_item.triggered_now;
        any_inside_nxt  = 1'b0;
        all_outside_nxt = 1'b1;
      end else begin
        any_inside_nxt  = acc_inside;
        all_outside_nxt = acc_outside;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      any_inside_r  <= 1'b0;
      all_outside_r <= 1'b1;
    end else begin
      armed_r       <= armed_nxt;
      any_inside_r  <= any_inside_nxt;
      all_outside_r <= all_outside_nxt;
    end
  end

  a_armed_moves_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    !res_push |=> armed_r == $past(armed_r))
    else $error("trigger state changed without an update end");

  a_fire_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && (res_item.change_code == CHG_FIRED)) |-> !armed_r)
    else $error("fire reported while already armed");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (!any_inside_r && all_outside_r))
    else $error("accumulators not cleared after update end");

endmodule

FILE: rtl/core/multi_axis_window_trigger_top.sv
// ----------------------------------------------------------------------------
// multi_axis_window_trigger_top: multi-axis window trigger with hysteresis
// Per-axis window lanes, a merge stage with update accumulators, and a
// two-entry output buffer.
// ----------------------------------------------------------------------------
// Points stream in one per transfer and are grouped into updates: a transfer
// with last_point set, or one with point_valid clear (an empty or cut-short
// update), closes the update and produces exactly one result transfer; all
// other transfers produce none. Each of the AXES lanes tests its axis value
// against its window in parallel, and the merge stage folds the lane flags
// into two one-bit accumulators, so the block takes one point every clock
// cycle while in_stall is low. An update's result is registered into the
// output register, or into the skid register behind it if that is held;
// in_stall rises only while both hold unclaimed results, so points that do
// not close an update are never held back by a slow consumer until two
// results are pending. Configuration writes take effect at the next clock
// edge and must only be issued while no update is in progress.
// ----------------------------------------------------------------------------
module multi_axis_window_trigger_top
  import mawt_pkg::*;
#(
  parameter int AXES = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Point input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data,
  // Configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WIN_BITS-1:0]     cfg_wdata
);

  // Configuration registers: one window per lane plus the two masks.
  logic [WIN_BITS-1:0] window_r [AXES];
  logic [AXES-1:0]     invert_r;
  logic [AXES-1:0]     enable_r;

  logic signed [VALUE_BITS-1:0] axis_vals [MAX_AXES];
  lane_flags_t [AXES-1:0]       lane_flags;

  logic      item_accept;
  logic      res_push;
  out_item_t res_item;

  // Output buffer: main register drives the port, skid catches one more.
  logic      main_v_r, main_v_nxt;
  out_item_t main_r, main_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  // Window registers: each lane's register answers to its own index.
  for (genvar g = 0; g < AXES; g++) begin : g_window
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        window_r[g] <= '0;
      end else if (cfg_we && (cfg_index == CFG_WINDOW_0 + CFG_IDX_BITS'(g))) begin
        window_r[g] <= cfg_wdata;
      end
    end
  end

  // Mask bits of axes beyond AXES are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= '0;
      enable_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INVERT: invert_r <= cfg_wdata[AXES-1:0];
        CFG_ENABLE: enable_r <= cfg_wdata[AXES-1:0];
        default: ;
      endcase
    end
  end

  assign axis_vals[0] = in_data.axis_value_0;
  assign axis_vals[1] = in_data.axis_value_1;
  assign axis_vals[2] = in_data.axis_value_2;
  assign axis_vals[3] = in_data.axis_value_3;

  // One comparator lane per axis, all working on the same point.
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    mawt_lane u_lane (
      .value   (axis_vals[g]),
      .present (in_data.present_mask[g]),
      .enable  (enable_r[g]),
      .invert  (invert_r[g]),
      .window  (window_r[g]),
      .flags   (lane_flags[g])
    );
  end

  // Hold input only when both result slots are occupied.
  assign in_stall    = skid_v_r;
  assign item_accept = in_valid && !in_stall;

  mawt_merge #(
    .AXES (AXES)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (item_accept),
    .point_valid (in_data.point_valid),
    .last_point  (in_data.last_point),
    .lane_flags  (lane_flags),
    .res_push    (res_push),
    .res_item    (res_item)
  );

  assign pop = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    main_nxt   = main_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!main_v_r || pop) begin
      // Main slot frees up: advance the skid entry, or load the new result.
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt   = skid_r;
        skid_v_nxt = res_push;
        skid_nxt   = res_item;
      end else begin
        main_v_nxt = res_push;
        main_nxt   = res_item;
      end
    end else if (res_push) begin
      // Main is stalled: park the new result in the skid register.
      skid_v_nxt = 1'b1;
      skid_nxt   = res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !skid_v_r)
    else $error("result produced while both output slots are full");

  a_stalled_push_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && out_stall && res_push) |=> skid_v_r)
    else $error("result lost while output register was stalled");

endmodule
